@@ rtl/core/dbps_pkg.sv @@
`timescale 1ns / 1ps

package dbps_pkg;

    localparam int MAX_ORDER  = 6;
    localparam int ENTRY_BITS = 8;
    localparam int DEPTH      = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W     = 6;
    localparam int IDX_W      = 3;
    localparam int SIZE_W     = 3;
    localparam int DET_W      = 56;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd3;

    // controller to datapath
    typedef struct packed {
        logic load;       // store one entry
        logic walk_init;  // last entry: clear walk state
        logic step;       // one step of the permutation walk
        logic leaf_run;   // product of the current permutation
        logic accumulate; // add or subtract the product
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic load_last;
        logic at_leaf;
        logic leaf_fin;
        logic walk_done;
    } sts_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_LEAF = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

@@ rtl/core/dbps_ctrl.sv @@
`timescale 1ns / 1ps

module dbps_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dbps_pkg::sts_t  sts,
    output dbps_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    dbps_pkg::state_t state_reg;
    dbps_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            dbps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.load_last)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = dbps_pkg::ST_WALK;
                    end
                end
            end
            dbps_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
                if (sts.at_leaf)
                begin
                    state_next = dbps_pkg::ST_LEAF;
                end
                else if (sts.walk_done)
                begin
                    state_next = dbps_pkg::ST_EMIT;
                end
            end
            dbps_pkg::ST_LEAF:
            begin
                cmd.leaf_run = 1'b1;
                if (sts.leaf_fin)
                begin
                    state_next = dbps_pkg::ST_ACC;
                end
            end
            dbps_pkg::ST_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = dbps_pkg::ST_WALK;
            end
            dbps_pkg::ST_EMIT:
            begin
                state_next = dbps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dbps_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dbps_pkg::ST_IDLE);
    assign done = (state_reg == dbps_pkg::ST_EMIT);

endmodule

@@ rtl/core/dbps_dp.sv @@
`timescale 1ns / 1ps

module dbps_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dbps_pkg::cmd_t                         cmd,
    output dbps_pkg::sts_t                         sts,
    input  logic signed [dbps_pkg::ENTRY_BITS-1:0] entry_value,
    input  logic                                   cfg_write,
    input  logic [dbps_pkg::SIZE_W-1:0]            cfg_data,
    output logic signed [dbps_pkg::DET_W-1:0]      determinant
);

    // entry memory, row-major at stride n
    logic signed [dbps_pkg::ENTRY_BITS-1:0] mem [dbps_pkg::DEPTH];

    logic [dbps_pkg::SIZE_W-1:0]        size_reg;
    logic [dbps_pkg::ADDR_W-1:0]        load_count_reg;
    logic [dbps_pkg::IDX_W-1:0]         col_reg [dbps_pkg::MAX_ORDER];
    logic [dbps_pkg::IDX_W-1:0]         col_next [dbps_pkg::MAX_ORDER];
    logic [dbps_pkg::IDX_W-1:0]         cur_reg [dbps_pkg::MAX_ORDER];
    logic [dbps_pkg::IDX_W-1:0]         pos_reg;
    logic                               up_reg;
    logic                               sign_reg;
    logic                               sign_next;
    logic signed [dbps_pkg::DET_W-1:0]  sum_reg;
    logic signed [dbps_pkg::DET_W-1:0]  prod_reg;
    logic [dbps_pkg::IDX_W-1:0]         row_reg;
    logic                               mul_vld_reg;
    logic                               mul_last_reg;
    logic                               fin_reg;
    logic signed [dbps_pkg::ENTRY_BITS-1:0] rd_reg;

    logic [dbps_pkg::IDX_W-1:0]  n;
    logic [dbps_pkg::ADDR_W-1:0] total;
    logic [dbps_pkg::IDX_W-1:0]  cp;
    logic [dbps_pkg::IDX_W-1:0]  cn;
    logic                        c_ok;
    logic                        issue;
    logic [dbps_pkg::ADDR_W-1:0] rd_addr;

    // order in use, clamped to 1..MAX_ORDER
    always_comb
    begin
        if (size_reg == '0)
        begin
            n = dbps_pkg::IDX_W'(1);
        end
        else if (size_reg > dbps_pkg::SIZE_W'(dbps_pkg::MAX_ORDER))
        begin
            n = dbps_pkg::IDX_W'(dbps_pkg::MAX_ORDER);
        end
        else
        begin
            n = size_reg;
        end
    end

    assign total = dbps_pkg::ADDR_W'(n) * dbps_pkg::ADDR_W'(n);

    // next swap position at the current depth
    assign cp   = cur_reg[pos_reg];
    assign cn   = cp + dbps_pkg::IDX_W'(1);
    assign c_ok = (cn < n);

    // undo the previous swap, then apply the next one
    always_comb
    begin
        col_next  = col_reg;
        sign_next = sign_reg;
        if (cp != pos_reg)
        begin
            col_next[pos_reg] = col_reg[cp];
            col_next[cp]      = col_reg[pos_reg];
            sign_next         = ~sign_next;
        end
        if (c_ok)
        begin
            col_next[cn]      = col_next[pos_reg];
            col_next[pos_reg] = col_reg[cn];
            sign_next         = ~sign_next;
        end
    end

    assign sts.load_last = ({1'b0, load_count_reg} + 7'd1) >= {1'b0, total};
    assign sts.at_leaf   = !up_reg && (pos_reg == n);
    assign sts.leaf_fin  = fin_reg;
    assign sts.walk_done = up_reg && !c_ok && (pos_reg == '0);

    // leaf product read address: row * n + column
    assign issue   = cmd.leaf_run && (row_reg < n);
    assign rd_addr = dbps_pkg::ADDR_W'(row_reg) * dbps_pkg::ADDR_W'(n)
                   + dbps_pkg::ADDR_W'(col_reg[row_reg]);

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && (load_count_reg < dbps_pkg::ADDR_W'(dbps_pkg::DEPTH)))
        begin
            mem[load_count_reg] <= entry_value;
        end
        if (issue)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // product and sum, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.step && sts.at_leaf)
        begin
            prod_reg <= dbps_pkg::DET_W'(1);
        end
        else if (mul_vld_reg)
        begin
            prod_reg <= prod_reg * dbps_pkg::DET_W'(rd_reg);
        end
        if (cmd.walk_init)
        begin
            sum_reg <= '0;
        end
        else if (cmd.accumulate)
        begin
            sum_reg <= sign_reg ? (sum_reg - prod_reg) : (sum_reg + prod_reg);
        end
    end

    assign determinant = sum_reg;

    // control state of load and walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= dbps_pkg::SIZE_RESET;
            load_count_reg <= '0;
            pos_reg        <= '0;
            up_reg         <= 1'b0;
            sign_reg       <= 1'b0;
            row_reg        <= '0;
            mul_vld_reg    <= 1'b0;
            mul_last_reg   <= 1'b0;
            fin_reg        <= 1'b0;
            for (int i = 0; i < dbps_pkg::MAX_ORDER; i++)
            begin
                col_reg[i] <= dbps_pkg::IDX_W'(i);
                cur_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                load_count_reg <= sts.load_last ? '0 : load_count_reg + dbps_pkg::ADDR_W'(1);
            end
            if (cmd.walk_init)
            begin
                pos_reg  <= '0;
                up_reg   <= 1'b0;
                sign_reg <= 1'b0;
                for (int i = 0; i < dbps_pkg::MAX_ORDER; i++)
                begin
                    col_reg[i] <= dbps_pkg::IDX_W'(i);
                end
            end
            else if (cmd.step)
            begin
                if (sts.at_leaf)
                begin
                    row_reg     <= '0;
                    mul_vld_reg <= 1'b0;
                    fin_reg     <= 1'b0;
                end
                else if (!up_reg)
                begin
                    // keep the current column and go deeper
                    cur_reg[pos_reg] <= pos_reg;
                    pos_reg          <= pos_reg + dbps_pkg::IDX_W'(1);
                end
                else
                begin
                    col_reg  <= col_next;
                    sign_reg <= sign_next;
                    if (c_ok)
                    begin
                        cur_reg[pos_reg] <= cn;
                        pos_reg          <= pos_reg + dbps_pkg::IDX_W'(1);
                        up_reg           <= 1'b0;
                    end
                    else if (pos_reg != '0)
                    begin
                        pos_reg <= pos_reg - dbps_pkg::IDX_W'(1);
                    end
                end
            end
            else if (cmd.leaf_run)
            begin
                if (issue)
                begin
                    row_reg <= row_reg + dbps_pkg::IDX_W'(1);
                end
                mul_vld_reg  <= issue;
                mul_last_reg <= issue && (row_reg == n - dbps_pkg::IDX_W'(1));
                fin_reg      <= mul_vld_reg && mul_last_reg;
            end
            else if (cmd.accumulate)
            begin
                // back up from the leaf
                pos_reg <= pos_reg - dbps_pkg::IDX_W'(1);
                up_reg  <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/determinant_by_permutation_sum.sv @@
// Entries load at one per cycle while start is held and the block is idle; the last entry starts
// the permutation walk, which forms the product of each permutation at its leaf and adds or
// subtracts it by sign; done follows in the next cycle after the walk ends.
// Throughput: one matrix at a time; busy holds off entries and size writes during the walk.
// Reset: asynchronous, clears the load count and walk state, size becomes 3.
// The determinant is valid with done and holds until the next walk starts; the receiver cannot stall.
`timescale 1ns / 1ps

module determinant_by_permutation_sum
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [dbps_pkg::ENTRY_BITS-1:0] entry_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dbps_pkg::SIZE_W-1:0]            cfg_data,
    output logic                                   done,
    output logic signed [dbps_pkg::DET_W-1:0]      determinant
);

    dbps_pkg::cmd_t cmd;
    dbps_pkg::sts_t sts;
    logic           busy_int;

    // configuration is only written while idle
    assign cfg_ready = !busy_int;
    assign busy      = busy_int;

    dbps_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy_int),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy_int),
        .done  (done)
    );

    dbps_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .entry_value (entry_value),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .determinant (determinant)
    );

endmodule

@@ rtl/core/dbps_checker.sv @@
`timescale 1ns / 1ps

module dbps_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a result only comes out of a running walk
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    // one strobe per matrix
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // block is free again right after the result
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy after result");

    // a walk only begins on an accepted entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without transfer");

endmodule

bind determinant_by_permutation_sum dbps_checker u_dbps_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
